// ===== design/priority_lock_arbiter_defines.svh =====
// ----------------------------------------------------------------------------
// priority_lock_arbiter_defines
// Assertion macros for the lock arbiter checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LOCK_ARBITER_DEFINES_SVH
`define PRIORITY_LOCK_ARBITER_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define PLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PLA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// pla_pkg
// Types, codes and helpers for the priority lock arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pla_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] requester_pid;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [15:0] grant_pid;
      logic        holding;
      logic [1:0]  status;
      logic [6:0]  queue_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK_START,
      S_COMPARE,
      S_PLACE,
      S_POP
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GRANT,
      OP_FULL,
      OP_REFUSE,
      OP_FREE,
      OP_QUERY,
      OP_NOP_RSP,
      OP_WALK_INIT,
      OP_READ,
      OP_SHIFT,
      OP_PLACE,
      OP_POP_READ,
      OP_POP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       held;
      logic       owner_match;
      logic       empty;
      logic       full;
      logic       walk_done;   // hole at logical slot zero
      logic       walk_last;   // one entry left to compare
      logic       above;       // read entry is greater than the new id
   } dp_status_type;

   function automatic addr_type addr_next(addr_type a);
      return (a == addr_type'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic addr_type addr_prev(addr_type a);
      return (a == '0) ? addr_type'(QUEUE_DEPTH - 1) : a - 1'b1;
   endfunction

   // physical slot of logical index c counted from head h
   function automatic addr_type addr_offset(addr_type h, count_type c);
      logic [ADDR_W:0] s;
      s = {1'b0, h} + (ADDR_W+1)'(c);
      if (s >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
         s = s - (ADDR_W+1)'(QUEUE_DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [6:0] to_qcount(count_type c);
      logic [31:0] w;
      w = 32'(c);
      return w[6:0];
   endfunction

endpackage

// ===== design/pla_ctrl.sv =====
// ----------------------------------------------------------------------------
// pla_ctrl
// Command sequencer: decodes an item, runs the sorted insert walk or head pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pla_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pla_pkg::dp_status_type dp_status,
   output pla_pkg::dp_cmd_type    dp_cmd
);
   import pla_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = OP_NONE;
      busy      = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.op = OP_LOAD;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (dp_status.cmd)
               CMD_ACQUIRE: begin
                  if (!dp_status.held) begin
                     dp_cmd.op = OP_GRANT;
                  end else if (dp_status.full) begin
                     dp_cmd.op = OP_FULL;
                  end else begin
                     dp_cmd.op = OP_WALK_INIT;
                     state_in  = S_WALK_START;
                  end
               end
               CMD_RELEASE: begin
                  if (!dp_status.held || !dp_status.owner_match) begin
                     dp_cmd.op = OP_REFUSE;
                  end else if (dp_status.empty) begin
                     dp_cmd.op = OP_FREE;
                  end else begin
                     dp_cmd.op = OP_POP_READ;
                     state_in  = S_POP;
                  end
               end
               CMD_QUERY: begin
                  dp_cmd.op = OP_QUERY;
               end
               default: begin
                  dp_cmd.op = OP_NOP_RSP;
               end
            endcase
         end
         S_WALK_START: begin
            if (dp_status.walk_done) begin
               dp_cmd.op = OP_PLACE;
               state_in  = S_IDLE;
            end else begin
               dp_cmd.op = OP_READ;
               state_in  = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (dp_status.above) begin
               dp_cmd.op = OP_SHIFT;
               state_in  = dp_status.walk_last ? S_PLACE : S_COMPARE;
            end else begin
               dp_cmd.op = OP_PLACE;
               state_in  = S_IDLE;
            end
         end
         S_PLACE: begin
            dp_cmd.op = OP_PLACE;
            state_in  = S_IDLE;
         end
         S_POP: begin
            dp_cmd.op = OP_POP_DONE;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/pla_datapath.sv =====
// ----------------------------------------------------------------------------
// pla_datapath
// Lock state, circular sorted wait queue in RAM, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pla_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pla_pkg::dp_cmd_type    dp_cmd,
   input  pla_pkg::req_type       req_data,
   output pla_pkg::dp_status_type dp_status,
   output logic                   rsp_strobe,
   output pla_pkg::rsp_type       rsp_data
);
   import pla_pkg::*;

   logic [15:0] queue_mem [QUEUE_DEPTH];

   logic        held_ff,   held_in;
   logic [15:0] owner_ff,  owner_in;
   addr_type    head_ff,   head_in;
   count_type   count_ff,  count_in;
   logic [1:0]  cmd_ff,    cmd_in;
   logic [15:0] pid_ff,    pid_in;
   addr_type    hole_ff,   hole_in;
   count_type   idx_ff,    idx_in;
   logic        strobe_ff, strobe_in;
   rsp_type     rsp_ff,    rsp_in;
   logic [15:0] rd_data_ff;

   logic        rd_en;
   addr_type    rd_addr;
   logic        wr_en;
   addr_type    wr_addr;
   logic [15:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         owner_ff  <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         held_ff   <= held_in;
         owner_ff  <= owner_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      pid_ff  <= pid_in;
      hole_ff <= hole_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= queue_mem[rd_addr];
      end
   end

   always_comb begin
      held_in   = held_ff;
      owner_in  = owner_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      pid_in    = pid_ff;
      hole_in   = hole_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_en     = 1'b0;
      rd_addr   = addr_prev(hole_ff);
      wr_en     = 1'b0;
      wr_addr   = hole_ff;
      wr_data   = pid_ff;
      case (dp_cmd.op)
         OP_LOAD: begin
            cmd_in = req_data.cmd;
            pid_in = req_data.requester_pid;
         end
         OP_GRANT: begin
            held_in          = 1'b1;
            owner_in         = pid_ff;
            strobe_in        = 1'b1;
            rsp_in.granted   = 1'b1;
            rsp_in.grant_pid = pid_ff;
            rsp_in.holding   = 1'b0;
            rsp_in.status    = STATUS_OK;
         end
         OP_FULL, OP_REFUSE, OP_FREE, OP_QUERY, OP_NOP_RSP: begin
            strobe_in        = 1'b1;
            rsp_in.granted   = 1'b0;
            rsp_in.grant_pid = '0;
            rsp_in.holding   = 1'b0;
            rsp_in.status    = STATUS_OK;
            if (dp_cmd.op == OP_FULL) begin
               rsp_in.status = STATUS_FULL;
            end
            if (dp_cmd.op == OP_REFUSE) begin
               rsp_in.status = STATUS_REFUSED;
            end
            if (dp_cmd.op == OP_FREE) begin
               held_in  = 1'b0;
               owner_in = '0;
            end
            if (dp_cmd.op == OP_QUERY) begin
               rsp_in.holding = held_ff && (owner_ff == pid_ff);
            end
         end
         OP_WALK_INIT: begin
            hole_in = addr_offset(head_ff, count_ff);
            idx_in  = count_ff;
         end
         OP_READ: begin
            rd_en = 1'b1;
         end
         OP_SHIFT: begin
            // move the larger entry up one slot, fetch the next one below
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            hole_in = addr_prev(hole_ff);
            idx_in  = idx_ff - 1'b1;
            rd_en   = 1'b1;
            rd_addr = addr_prev(addr_prev(hole_ff));
         end
         OP_PLACE: begin
            wr_en            = 1'b1;
            count_in         = count_ff + 1'b1;
            strobe_in        = 1'b1;
            rsp_in.granted   = 1'b0;
            rsp_in.grant_pid = '0;
            rsp_in.holding   = 1'b0;
            rsp_in.status    = STATUS_OK;
         end
         OP_POP_READ: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         OP_POP_DONE: begin
            owner_in         = rd_data_ff;
            head_in          = addr_next(head_ff);
            count_in         = count_ff - 1'b1;
            strobe_in        = 1'b1;
            rsp_in.granted   = 1'b1;
            rsp_in.grant_pid = rd_data_ff;
            rsp_in.holding   = 1'b0;
            rsp_in.status    = STATUS_OK;
         end
         default: begin
         end
      endcase
      if (strobe_in) begin
         rsp_in.queue_count = to_qcount(count_in);
      end
   end

   always_comb begin
      dp_status.cmd         = cmd_ff;
      dp_status.held        = held_ff;
      dp_status.owner_match = (owner_ff == pid_ff);
      dp_status.empty       = (count_ff == '0);
      dp_status.full        = (count_ff == count_type'(QUEUE_DEPTH));
      dp_status.walk_done   = (idx_ff == '0);
      dp_status.walk_last   = (idx_ff == count_type'(1));
      dp_status.above       = (rd_data_ff > pid_ff);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/priority_lock_arbiter.sv =====
// ----------------------------------------------------------------------------
// priority_lock_arbiter
// Mutual-exclusion lock with a wait queue kept sorted by ascending id.
// ----------------------------------------------------------------------------
// Channel   Ports                       Handshake
// input     req_data (cmd, pid)         accepted when start && !busy
// result    rsp_data (grant, status..)  valid for one cycle while rsp_strobe
//
// A release with handover does one RAM read of the queue head. An acquire that
// queues runs the insert walk, which moves each waiter with a larger id up one
// slot, one per cycle over the single-write, single-read queue RAM (at most
// QUEUE_DEPTH - 1 waiters).
// Reset is synchronous and leaves the lock free with an empty queue; queue
// RAM contents are not cleared since only slots below the count are read.
// The result cannot be stalled; busy drops in the cycle the strobe rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_lock_arbiter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pla_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pla_pkg::rsp_type rsp_data
);
   import pla_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: decode, insert walk, head pop
   pla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // queue is a circular buffer: head pointer gives O(1) pop, insert walks
   // backward from the tail shifting larger ids up until the slot is found
   pla_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .req_data   (req_data),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/pla_checker.sv =====
// ----------------------------------------------------------------------------
// pla_checker
// Port-level temporal checks for the priority lock arbiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_lock_arbiter_defines.svh"

module pla_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input pla_pkg::rsp_type rsp_data
);
   import pla_pkg::*;

   `PLA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `PLA_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "strobe repeated")
   `PLA_ASSERT_SAME(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy), "stray result")
   `PLA_ASSERT_SAME(a_hold_clean, clock, reset, rsp_strobe && rsp_data.holding, !rsp_data.granted && (rsp_data.status == STATUS_OK), "holding with grant")

endmodule

bind priority_lock_arbiter pla_checker u_pla_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority lock arbiter. A directed table runs
// first, then random acquire/release episodes that fill and drain the wait
// queue. Results are checked against a typed row's answer or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import pla_pkg::*;

   // opcode 3 has no meaning; the block must answer it and change nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int TOTAL_ITEMS    = 1450;
   localparam int DIR_ROWS       = 25;
   localparam int WATCHDOG_LIMIT = 2000;
   // a queued acquire moves at most QUEUE_DEPTH - 1 waiters up one slot
   localparam int DRAIN_CYCLES   = QUEUE_DEPTH + 16;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] pid;
      logic        typed;
      rsp_type     answer;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // lock model state
   logic        held_now;
   logic [15:0] owner_now;
   logic [15:0] waiters[$];

   rsp_type expected_rsps[$];
   int unsigned error_count   = 0;
   int unsigned result_index  = 0;
   int unsigned items_sent    = 0;
   int unsigned burst_left    = 0;
   int unsigned quiet_cycles  = 0;

   // pid shaping for the current random episode
   int unsigned pid_mode;
   logic [15:0] pid_base;

   dir_row_type directed_rows [DIR_ROWS] = '{
      // fresh lock: nobody holds it, releases are refused
      '{CMD_QUERY,   16'h0005, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_OK,      7'd0}},
      '{CMD_RELEASE, 16'h0005, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_REFUSED, 7'd0}},
      // id zero is an ordinary id
      '{CMD_ACQUIRE, 16'h0000, 1'b1, '{1'b1, 16'h0000, 1'b0, STATUS_OK,      7'd0}},
      '{CMD_QUERY,   16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b1, STATUS_OK,      7'd0}},
      '{CMD_ACQUIRE, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_OK,      7'd1}},
      '{CMD_ACQUIRE, 16'h8000, 1'b0, '0},
      // equal id lands behind the earlier one
      '{CMD_ACQUIRE, 16'hFFFF, 1'b0, '0},
      // owner queues behind itself, at the head
      '{CMD_ACQUIRE, 16'h0000, 1'b0, '0},
      '{CMD_ACQUIRE, 16'h0001, 1'b0, '0},
      '{CMD_RELEASE, 16'h0007, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_REFUSED, 7'd5}},
      '{CMD_UNUSED,  16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_OK,      7'd5}},
      '{CMD_QUERY,   16'hFFFF, 1'b0, '0},
      // handovers walk the queue in ascending order
      '{CMD_RELEASE, 16'h0000, 1'b0, '0},
      '{CMD_RELEASE, 16'h0000, 1'b0, '0},
      '{CMD_RELEASE, 16'h0001, 1'b0, '0},
      '{CMD_QUERY,   16'h8000, 1'b0, '0},
      '{CMD_RELEASE, 16'h8000, 1'b0, '0},
      '{CMD_RELEASE, 16'hFFFF, 1'b0, '0},
      // empty queue: release frees the lock, a second one is refused
      '{CMD_RELEASE, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_OK,      7'd0}},
      '{CMD_RELEASE, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, STATUS_REFUSED, 7'd0}},
      '{CMD_ACQUIRE, 16'hAAAA, 1'b1, '{1'b1, 16'hAAAA, 1'b0, STATUS_OK,      7'd0}},
      '{CMD_ACQUIRE, 16'h5555, 1'b0, '0},
      '{CMD_UNUSED,  16'h5555, 1'b0, '0},
      '{CMD_RELEASE, 16'hAAAA, 1'b0, '0},
      '{CMD_RELEASE, 16'h5555, 1'b0, '0}
   };

   priority_lock_arbiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- lock model ---------------------------------------------------------

   // applies one item to the model and returns the answer the block owes
   function automatic rsp_type lock_predict(logic [1:0] cmd, logic [15:0] pid);
      rsp_type r;
      int      pos;
      r = '0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_ACQUIRE: begin
            if (!held_now) begin
               held_now    = 1'b1;
               owner_now   = pid;
               r.granted   = 1'b1;
               r.grant_pid = pid;
            end else if (waiters.size() >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // equal ids keep arrival order: stop at the first larger id
               pos = 0;
               while (pos < waiters.size() && waiters[pos] <= pid) pos++;
               waiters.insert(pos, pid);
            end
         end
         CMD_RELEASE: begin
            if (!held_now || owner_now != pid) begin
               r.status = STATUS_REFUSED;
            end else if (waiters.size() > 0) begin
               owner_now   = waiters.pop_front();
               r.granted   = 1'b1;
               r.grant_pid = owner_now;
            end else begin
               held_now  = 1'b0;
               owner_now = '0;
            end
         end
         CMD_QUERY: begin
            r.holding = held_now && (owner_now == pid);
         end
         default: ;
      endcase
      r.queue_count = 7'(waiters.size());
      return r;
   endfunction

   // ---- driving ------------------------------------------------------------

   function automatic int unsigned pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(1, 4);
         6, 7, 8:          return $urandom_range(5, 30);
         default:          return $urandom_range(31, 90);
      endcase
   endfunction

   task automatic idle_for(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'($urandom);
      end
   endtask

   // presents one item, waits for the accept edge, then logs what is owed
   task automatic send_item(logic [1:0] cmd, logic [15:0] pid, logic typed,
                            rsp_type answer);
      rsp_type want;
      if (burst_left == 0) begin
         idle_for(pick_gap());
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{cmd: cmd, requester_pid: pid};
      do @(posedge clock); while (busy);
      want = lock_predict(cmd, pid);
      if (typed) want = answer;
      expected_rsps.push_back(want);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // holds off the sender until every answer is back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_pid();
      logic [15:0] corner[4];
      corner = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
      case (pid_mode)
         0:       return 16'($urandom_range(0, 7));     // heavy on equal ids
         1:       return 16'($urandom_range(0, 65535));
         2:       return pid_base + 16'($urandom_range(0, 31));
         default: return corner[$urandom_range(0, 3)];
      endcase
   endfunction

   // off-path traffic mixed into the well-formed sequences
   task automatic send_noise();
      logic [15:0] who;
      who = held_now ? owner_now : pick_pid();
      case ($urandom_range(0, 5))
         0: send_item(CMD_QUERY, who, 1'b0, '0);
         1: send_item(CMD_QUERY, pick_pid(), 1'b0, '0);
         2: send_item(CMD_RELEASE, pick_pid(), 1'b0, '0);   // mostly refused
         3: send_item(CMD_UNUSED, 16'($urandom), 1'b0, '0);
         4: send_item(CMD_ACQUIRE, who, 1'b0, '0);          // owner re-acquires
         default: send_item(2'($urandom), 16'($urandom), 1'b0, '0);
      endcase
   endtask

   // one episode: take the lock, pile up waiters, hand the lock down the queue
   task automatic run_episode();
      int unsigned fill;
      int unsigned drain_cap;
      int unsigned n;
      pid_mode = $urandom_range(0, 3);
      pid_base = 16'($urandom);
      // some episodes overfill to hit the queue-full case repeatedly
      fill = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72)
                                         : $urandom_range(0, 20);
      drain_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 1000;
      if (!held_now) send_item(CMD_ACQUIRE, pick_pid(), 1'b0, '0);
      n = 0;
      while (n < fill) begin
         if ($urandom_range(0, 7) == 0) begin
            send_noise();
         end else begin
            send_item(CMD_ACQUIRE, pick_pid(), 1'b0, '0);
            n++;
         end
      end
      n = 0;
      while (held_now && n < drain_cap) begin
         if ($urandom_range(0, 7) == 0) begin
            send_noise();
         end else begin
            send_item(CMD_RELEASE, owner_now, 1'b0, '0);
            n++;
         end
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
   endtask

   // ---- checking -----------------------------------------------------------

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 50) $display("ERROR: result %0d: %s", result_index, msg);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got)
         report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = expected_rsps.pop_front();
            check_field("granted",     want.granted,     rsp_data.granted);
            check_field("grant_pid",   want.grant_pid,   rsp_data.grant_pid);
            check_field("holding",     want.holding,     rsp_data.holding);
            check_field("status",      want.status,      rsp_data.status);
            check_field("queue_count", want.queue_count, rsp_data.queue_count);
         end
         result_index++;
      end
   end

   // ends the run if neither an accept nor a result shows up for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---- main sequence ------------------------------------------------------

   initial begin : stimulus
      int i;
      held_now  = 1'b0;
      owner_now = '0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         send_item(directed_rows[i].cmd, directed_rows[i].pid,
                   directed_rows[i].typed, directed_rows[i].answer);
      end
      wait_drained();

      while (items_sent < TOTAL_ITEMS) run_episode();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pla_pkg.sv
design/pla_ctrl.sv
design/pla_datapath.sv
design/priority_lock_arbiter.sv
design/pla_checker.sv
tb/tb_top.sv
